@@ hdl/stbs_pkg.sv @@
// shared types and constants for the sorted table binary search block
package stbs_pkg;

    localparam int unsigned KEY_W    = 32;
    localparam int unsigned INDEX_W  = 9;
    localparam int unsigned COUNT_W  = 10;
    localparam int unsigned PROBES_W = 4;

    typedef enum logic
    {
        OP_LOAD   = 1'b0,
        OP_SEARCH = 1'b1
    } stbs_op_t;

    typedef struct packed
    {
        logic [PROBES_W-1:0] comparisons;
        logic                found;
    } stbs_result_t;

endpackage

@@ hdl/stbs_table_ram.sv @@
// key table: one write port, one read port, registered read data
module stbs_table_ram #(
    parameter int unsigned TABLE_DEPTH = 512
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] waddr,
    input  logic [stbs_pkg::KEY_W-1:0]    wdata,
    input  logic                          re,
    input  logic [$clog2(TABLE_DEPTH)-1:0] raddr,
    output logic [stbs_pkg::KEY_W-1:0]    rdata
);
    import stbs_pkg::*;

    logic [KEY_W-1:0] key_mem_reg [TABLE_DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= key_mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/stbs_search_ctrl.sv @@
// search sequencer: holds the bounds, issues probe reads and compares
module stbs_search_ctrl #(
    parameter int unsigned TABLE_DEPTH = 512
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            begin_search,
    input  logic [stbs_pkg::COUNT_W-1:0]    entry_count,
    input  logic [stbs_pkg::KEY_W-1:0]      target_value,
    input  logic [stbs_pkg::KEY_W-1:0]      rdata,
    output logic                            re,
    output logic [$clog2(TABLE_DEPTH)-1:0]  raddr,
    output logic                            busy,
    output logic                            done,
    output stbs_pkg::stbs_result_t          result
);
    import stbs_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW = (NW > COUNT_W) ? NW : COUNT_W;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE
    } state_t;

    state_t               state_reg;
    logic [NW-1:0]        lo_reg;
    logic [NW-1:0]        hp_reg;     // high bound plus one
    logic [AW-1:0]        mid_reg;
    logic [KEY_W-1:0]     target_reg;
    logic [PROBES_W-1:0]  probes_reg;
    logic                 done_reg;
    stbs_result_t         result_reg;

    logic [NW-1:0]        n_sat;
    logic [CW-1:0]        count_ext;
    logic [NW:0]          mid_sum;
    logic [AW-1:0]        mid;
    logic [NW-1:0]        mid_plus1;
    logic [PROBES_W-1:0]  probes_next;
    logic                 key_eq;
    logic                 key_lt;

    // saturate the count to the table depth
    always_comb
    begin
        count_ext = CW'(entry_count);
        if (count_ext > CW'(TABLE_DEPTH))
        begin
            n_sat = NW'(TABLE_DEPTH);
        end
        else
        begin
            n_sat = count_ext[NW-1:0];
        end
    end

    // midpoint of lo and hi, rounding down
    assign mid_sum     = (NW + 1)'(lo_reg) + (NW + 1)'(hp_reg) - (NW + 1)'(1);
    assign mid         = mid_sum[AW:1];
    assign mid_plus1   = NW'(mid_reg) + NW'(1);
    assign probes_next = probes_reg + PROBES_W'(1);
    assign key_eq      = (rdata == target_reg);
    assign key_lt      = ($signed(rdata) < $signed(target_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            lo_reg     <= '0;
            hp_reg     <= '0;
            mid_reg    <= '0;
            target_reg <= '0;
            probes_reg <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (begin_search)
                    begin
                        target_reg <= target_value;
                        lo_reg     <= '0;
                        hp_reg     <= n_sat;
                        probes_reg <= '0;
                        if (n_sat == '0)
                        begin
                            // empty range: answer at once
                            done_reg               <= 1'b1;
                            result_reg.comparisons <= '0;
                            result_reg.found       <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= ST_PROBE;
                        end
                    end
                end
                ST_PROBE:
                begin
                    mid_reg   <= mid;
                    state_reg <= ST_COMPARE;
                end
                ST_COMPARE:
                begin
                    probes_reg <= probes_next;
                    if (key_eq)
                    begin
                        done_reg               <= 1'b1;
                        result_reg.comparisons <= probes_next;
                        result_reg.found       <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                    else if (key_lt)
                    begin
                        lo_reg <= mid_plus1;
                        if (mid_plus1 < hp_reg)
                        begin
                            state_reg <= ST_PROBE;
                        end
                        else
                        begin
                            done_reg               <= 1'b1;
                            result_reg.comparisons <= probes_next;
                            result_reg.found       <= 1'b0;
                            state_reg              <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        hp_reg <= NW'(mid_reg);
                        if (lo_reg < NW'(mid_reg))
                        begin
                            state_reg <= ST_PROBE;
                        end
                        else
                        begin
                            done_reg               <= 1'b1;
                            result_reg.comparisons <= probes_next;
                            result_reg.found       <= 1'b0;
                            state_reg              <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign re     = (state_reg == ST_PROBE);
    assign raddr  = mid;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/sorted_table_binary_search.sv @@
// top level of the sorted table binary search block
//
// a load transfer writes one key and never raises busy, so the next transfer
// may follow on the very next edge. a search transfer runs a binary search
// over the first entry_count keys (capped at TABLE_DEPTH): each probe has a
// read step, through the registered read port of the table memory, and a
// compare step that compares and narrows the bounds. a search that makes p
// probes holds busy while it probes and raises done after its last compare
// step; p is at most 10 since entry_count is at most 1023. with an empty
// range done comes on the cycle after the transfer and busy stays low. done
// is a one-cycle strobe with comparisons and found beside it: the receiver
// cannot stall it, so it must take the result on that cycle. busy is
// already low while done is high, so a new transfer can be started in the
// same cycle the result appears. entry_count is written through
// cfg_we/cfg_data and should only change while no search is running.
// the table memory has no reset; reading an entry that was never loaded
// gives an undefined key.
module sorted_table_binary_search #(
    parameter int unsigned TABLE_DEPTH = 512
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command channel
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic [stbs_pkg::INDEX_W-1:0]     load_index,
    input  logic signed [stbs_pkg::KEY_W-1:0] load_value,
    input  logic signed [stbs_pkg::KEY_W-1:0] target_value,
    // result channel
    output logic                             done,
    output logic [stbs_pkg::PROBES_W-1:0]    comparisons,
    output logic                             found,
    // configuration
    input  logic                             cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]     cfg_data
);
    import stbs_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    // one bit above both widths so the depth itself fits for the range check
    localparam int unsigned IW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

    logic [COUNT_W-1:0] entry_count_reg;

    logic               accept;
    logic               load_we;
    logic [IW-1:0]      index_ext;
    logic [AW-1:0]      waddr;
    logic               begin_search;
    logic               re;
    logic [AW-1:0]      raddr;
    logic [KEY_W-1:0]   rdata;
    stbs_result_t       result;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    assign accept = start && !busy;

    // loads beyond the table depth are dropped
    assign index_ext    = IW'(load_index);
    assign waddr        = index_ext[AW-1:0];
    assign load_we      = accept && (operation == OP_LOAD)
                          && (index_ext < IW'(TABLE_DEPTH));
    assign begin_search = accept && (operation == OP_SEARCH);

    // a load only lands while the sequencer is idle, so a write never meets
    // an outstanding probe read of the same entry
    stbs_table_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (waddr),
        .wdata (load_value),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    stbs_search_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .begin_search (begin_search),
        .entry_count  (entry_count_reg),
        .target_value (target_value),
        .rdata        (rdata),
        .re           (re),
        .raddr        (raddr),
        .busy         (busy),
        .done         (done),
        .result       (result)
    );

    assign comparisons = result.comparisons;
    assign found       = result.found;

endmodule

@@ hdl/stbs_checker.sv @@
// port-level checker for the sorted table binary search block, with its bind
module stbs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          operation,
    input logic                          done,
    input logic [stbs_pkg::PROBES_W-1:0] comparisons,
    input logic                          found
);
    import stbs_pkg::*;

    // the search range never exceeds 1023 entries, so at most ten probes
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (comparisons <= PROBES_W'(10)))
        else $error("too many probes reported");

    // a hit needs at least one probe
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (comparisons != '0))
        else $error("found without any probe");

    // a search either runs or answers at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_SEARCH)) |=> (busy || done))
        else $error("search transfer left no trace");

    // the result appears with the block already free
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while still busy");

    // a load gives no result and does not occupy the block
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_LOAD)) |=> (!busy && !done))
        else $error("load transfer produced activity");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .comparisons (comparisons),
    .found       (found)
);

@@ sim/tb_sorted_table_binary_search.sv @@
// self-checking testbench for the sorted table binary search block
module tb_sorted_table_binary_search;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int unsigned TABLE_DEPTH = 512;
    // covers the longest search of 10 probes, plus some margin
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned MAX_PRINTS = 100;

    // keeps its own copy of the table and the entry count, works out the
    // probe count and hit flag of every accepted search, and holds those
    // answers in arrival order until the block produces them
    class search_scoreboard;
        bit signed [KEY_W-1:0] key_table[TABLE_DEPTH];
        bit                    written[TABLE_DEPTH];
        bit [COUNT_W-1:0]      entry_count;
        stbs_result_t          pending_answers[$];
        int unsigned           mismatches;

        function void set_count(bit [COUNT_W-1:0] value);
            entry_count = value;
        endfunction

        // walks the same probe sequence as the block; safe drops to zero if
        // any probed entry has never been loaded
        function void probe_sequence(input bit signed [KEY_W-1:0] target,
                                     output stbs_result_t answer, output bit safe);
            int          n;
            int          lo;
            int          hi;
            int          mid;
            int unsigned probes;
            bit          hit;
            n = entry_count;
            if (n > int'(TABLE_DEPTH))
                n = TABLE_DEPTH;
            lo = 0;
            hi = n - 1;
            probes = 0;
            hit = 1'b0;
            safe = 1'b1;
            while (lo <= hi && !hit)
            begin
                mid = lo + (hi - lo) / 2;
                probes++;
                if (!written[mid])
                    safe = 1'b0;
                if (key_table[mid] == target)
                    hit = 1'b1;
                else if (key_table[mid] < target)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            answer.comparisons = probes[PROBES_W-1:0];
            answer.found = hit;
        endfunction

        function void note_transfer(stbs_op_t op, bit [INDEX_W-1:0] index,
                                    bit signed [KEY_W-1:0] value,
                                    bit signed [KEY_W-1:0] target);
            stbs_result_t answer;
            bit           safe;
            if (op == OP_LOAD)
            begin
                if (index < TABLE_DEPTH)
                begin
                    key_table[index] = value;
                    written[index] = 1'b1;
                end
            end
            else
            begin
                probe_sequence(target, answer, safe);
                pending_answers.push_back(answer);
            end
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t: mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [PROBES_W-1:0] comparisons, logic found);
            stbs_result_t want;
            if (pending_answers.size() == 0)
                report("search result with no search waiting");
            else
            begin
                want = pending_answers.pop_front();
                if (comparisons !== want.comparisons)
                    report($sformatf("comparisons got %0d want %0d",
                                     comparisons, want.comparisons));
                if (found !== want.found)
                    report($sformatf("found got %0b want %0b", found, want.found));
            end
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      operation;
    logic [INDEX_W-1:0]        load_index;
    logic signed [KEY_W-1:0]   load_value;
    logic signed [KEY_W-1:0]   target_value;
    logic                      done;
    logic [PROBES_W-1:0]       comparisons;
    logic                      found;
    logic                      cfg_we;
    logic [COUNT_W-1:0]        cfg_data;

    search_scoreboard sb = new;

    int unsigned items_sent = 0;
    int unsigned idle_pct = 30;
    // number of entries the current entry count actually covers
    int          span_in_use = 0;

    sorted_table_binary_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .load_index   (load_index),
        .load_value   (load_value),
        .target_value (target_value),
        .done         (done),
        .comparisons  (comparisons),
        .found        (found),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // results cannot be stalled, so every done strobe is a finished transfer;
    // values read here are the ones from before the edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(comparisons, found);
    end

    // one command transfer; returns in the time step of the accepting edge
    // with start still high, so the caller decides what start does next
    task automatic send(stbs_op_t op, logic [INDEX_W-1:0] index,
                        logic signed [KEY_W-1:0] value, logic signed [KEY_W-1:0] target);
        // sender idling: each cycle is held off with the current chance
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        operation    <= op;
        load_index   <= index;
        load_value   <= value;
        target_value <= target;
        do
            @(posedge clk);
        while (busy);
        sb.note_transfer(op, index, value, target);
        items_sent++;
        // thirty percent idling first, then sixty-three, then none at all
        idle_pct = (items_sent < 450) ? 30 : (items_sent < 900) ? 63 : 0;
    endtask

    // only issues a search whose probes all land on loaded entries
    task automatic try_search(logic signed [KEY_W-1:0] target);
        stbs_result_t answer;
        bit           safe;
        sb.probe_sequence(target, answer, safe);
        if (safe)
            send(OP_SEARCH, INDEX_W'($urandom), $urandom, target);
    endtask

    // drop start, let outstanding searches finish, then allow settling time
    task automatic wait_idle();
        start <= 1'b0;
        while (sb.pending_answers.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        sb.set_count(value);
        cfg_we   <= 1'b0;
        span_in_use = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
    endtask

    // loads n ascending keys into entries 0..n-1 in shuffled order; steps of
    // zero give duplicate keys now and then
    task automatic reload_prefix(int n);
        bit signed [KEY_W-1:0] keys[TABLE_DEPTH];
        int                    order[$];
        longint                cur;
        longint                step_max;
        int                    j;
        int                    tmp;
        step_max = 64'sd4294967295 / (n + 1);
        cur = -64'sd2147483648 + ($urandom % step_max);
        for (int k = 0; k < n; k++)
        begin
            keys[k] = cur[KEY_W-1:0];
            if ($urandom_range(9) != 0)
                cur += $urandom % step_max;
            order.push_back(k);
        end
        // now and then pin both ends of the range to the key extremes
        if ($urandom_range(4) == 0)
        begin
            keys[0]   = 32'sh8000_0000;
            keys[n-1] = 32'sh7fff_ffff;
        end
        for (int k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        foreach (order[k])
            send(OP_LOAD, INDEX_W'(order[k]), keys[order[k]], $urandom);
    endtask

    // mostly keys that are present, then near misses, extremes and noise
    function automatic logic signed [KEY_W-1:0] pick_target();
        int                    r;
        logic signed [KEY_W-1:0] key;
        r = $urandom_range(99);
        if (span_in_use > 0)
            key = sb.key_table[$urandom_range(span_in_use - 1)];
        else
            key = $urandom;
        if (r < 55)
            return key;
        if (r < 75)
            return ($urandom_range(1)) ? key + 1 : key - 1;
        if (r < 85)
        begin
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return 32'sh0000_0000;
                default: return 32'shffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin
        int unsigned      cnt;
        logic [INDEX_W-1:0] index;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        operation    <= OP_LOAD;
        load_index   <= '0;
        load_value   <= '0;
        target_value <= '0;
        cfg_we       <= 1'b0;
        cfg_data     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table straight after reset: no probes, never found
        try_search(32'sh8000_0000);
        try_search(32'sh7fff_ffff);

        // a tiny table spanning both key extremes, plus the top table entry
        send(OP_LOAD, 9'd0, 32'sh8000_0000, 32'sh7fff_ffff);
        send(OP_LOAD, 9'd1, 32'shffff_ffff, 32'sh0000_0000);
        send(OP_LOAD, 9'd2, 32'sh0000_0000, 32'shffff_ffff);
        send(OP_LOAD, 9'd3, 32'sh7fff_ffff, 32'sh8000_0000);
        send(OP_LOAD, 9'd511, 32'sh5a5a_5a5a, 32'sh0000_0000);
        wait_idle();
        write_count(10'd4);
        try_search(32'sh8000_0000);
        try_search(32'shffff_ffff);
        try_search(32'sh0000_0000);
        try_search(32'sh7fff_ffff);
        try_search(32'sh0000_0001);
        try_search(32'shffff_fffe);
        // single entry: one probe, hit or miss
        wait_idle();
        write_count(10'd1);
        try_search(32'sh8000_0000);
        try_search(32'sh7fff_ffff);

        // count beyond the table saturates to the full depth; fill it all
        wait_idle();
        write_count(10'd1023);
        reload_prefix(TABLE_DEPTH);
        repeat (25) try_search(pick_target());

        // phases at varied counts, mostly small ones with fresh tables
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0:       cnt = 0;
                1:       cnt = 1;
                2:       cnt = 2;
                3:       cnt = 512;
                4:       cnt = 513;
                default: cnt = ($urandom_range(9) < 7) ? $urandom_range(3, 64)
                                                       : $urandom_range(65, 1023);
            endcase
            wait_idle();
            write_count(cnt[COUNT_W-1:0]);
            if (span_in_use > 0 && span_in_use <= 64)
                reload_prefix(span_in_use);
            repeat (40)
            begin
                if ($urandom_range(3) == 0)
                begin
                    // loads mostly outside the searched range; the rest go to
                    // any entry and can leave the table unsorted
                    if (span_in_use < int'(TABLE_DEPTH) && $urandom_range(9) < 7)
                        index = INDEX_W'($urandom_range(span_in_use, TABLE_DEPTH - 1));
                    else
                        index = INDEX_W'($urandom_range(TABLE_DEPTH - 1));
                    send(OP_LOAD, index, $urandom, $urandom);
                end
                else
                    try_search(pick_target());
            end
        end

        start <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_answers.size() == 0)
            $display("sorted_table_binary_search test passed");
        else
            $display("sorted_table_binary_search test failed");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #2_000_000;
        $display("sorted_table_binary_search test failed");
        $finish;
    end

endmodule
